/* rtl/sbda_pkg.sv */
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and types of the signed binary to decimal ASCII converter:
// port widths, character codes, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package sbda_pkg;

  // default width of the converted integer
  localparam int VALUE_BITS = 64;

  // fixed port widths
  localparam int IN_BITS   = 64;
  localparam int CHAR_BITS = 6;
  localparam int OUT_BITS  = 8;

  // character codes
  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 6'd45;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_SIGN  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture a new item
    logic step;      // one double-dabble step
    logic emit;      // move to the next lower digit
    logic sel_sign;  // present the minus sign
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic negative;  // item is negative
    logic ptr_zero;  // current digit is the units digit
  } status_t;

endpackage

/* rtl/signed_binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// Converts a signed integer to its decimal ASCII text, one character per
// output item, most significant first.
// ----------------------------------------------------------------------------
// One item at a time: an accepted integer (low VALUE_BITS bits, two's
// complement) is turned into its magnitude in the accept cycle, then a
// bit-serial double-dabble unit forms the BCD digits, and the text leaves
// one character per cycle while the sink is ready: a minus sign for
// negative values, then the digits without leading zeros, the last one
// flagged with tlast. The next item is accepted in the cycle after the
// last character is taken.
module signed_binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sbda_pkg::IN_BITS-1:0]  s_axis_tdata,   // [63:0] value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sbda_pkg::OUT_BITS-1:0] m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic                          m_axis_tlast
);

  localparam int PAD_BITS = sbda_pkg::OUT_BITS - sbda_pkg::CHAR_BITS;

  sbda_pkg::cmd_t                 cmd;
  sbda_pkg::status_t              status;
  logic [sbda_pkg::CHAR_BITS-1:0] char_code;

  // control
  sbda_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .status    (status),
    .cmd       (cmd)
  );

  // conversion datapath
  sbda_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .value     (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code)
  );

  assign m_axis_tdata = {{PAD_BITS{1'b0}}, char_code};

  // never taking input while text is being sent
  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // an accepted item starts the conversion, nothing is shown meanwhile
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !m_axis_tvalid))
    else $error("conversion did not start after accept");

  // taking the last character frees the block for the next item
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("not idle after last character");

  // only a minus sign or a digit ever leaves
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata == 8'd45) ||
                       ((m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd57))))
    else $error("character code out of range");

endmodule

/* rtl/sbda_datapath.sv */
// ----------------------------------------------------------------------------
// sbda_datapath
// Magnitude shift register, bit-serial double-dabble BCD register with a
// leading-digit tracker, and the character output mux.
// ----------------------------------------------------------------------------
module sbda_datapath #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS
) (
  input  logic                             clk,
  input  logic [sbda_pkg::IN_BITS-1:0]     value,
  input  sbda_pkg::cmd_t                   cmd,
  output sbda_pkg::status_t                status,
  output logic [sbda_pkg::CHAR_BITS-1:0]   char_code
);

  // digits of the largest magnitude, 2^(VALUE_BITS-1)
  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int DIG_W = $clog2(NDIG);
  localparam int BCD_W = NDIG * 4;
  localparam logic [DIG_W-1:0] TOP_IDX = DIG_W'(NDIG - 1);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [DIG_W-1:0]      top;
  logic                  negative;

  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] mag_load;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCD_W-1:0]      bcd_shift;
  logic [DIG_W-1:0]      top_inc;
  logic                  grow;
  logic [3:0]            digit;

  // magnitude of the incoming item, upper bits ignored
  always_comb begin
    v_in     = value[VALUE_BITS-1:0];
    mag_load = v_in[VALUE_BITS-1] ? (~v_in + 1'b1) : v_in;
  end

  // add 3 to every digit of 5 or more, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3) : bcd[i*4 +: 4];
    end
    bcd_shift = {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
  end

  // the value at most doubles per step, so the leading digit moves up by one at most
  always_comb begin
    top_inc = top + 1'b1;
    grow    = (top != TOP_IDX) && (bcd_shift[top_inc*4 +: 4] != 4'd0);
  end

  // character of the current digit or the sign
  always_comb begin
    digit     = bcd[top*4 +: 4];
    char_code = cmd.sel_sign ? sbda_pkg::ASCII_MINUS
                             : sbda_pkg::ASCII_ZERO + {2'b00, digit};
  end

  assign status.negative = negative;
  assign status.ptr_zero = (top == '0);

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_load;
      bcd      <= '0;
      top      <= '0;
      negative <= v_in[VALUE_BITS-1];
    end else if (cmd.step) begin
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      bcd <= bcd_shift;
      if (grow) begin
        top <= top_inc;
      end
    end else if (cmd.emit) begin
      top <= top - 1'b1;
    end
  end

endmodule

/* rtl/sbda_ctrl.sv */
// ----------------------------------------------------------------------------
// sbda_ctrl
// Controller: takes an item, runs the bit-serial conversion for VALUE_BITS
// steps, then hands out the sign and the digits one per handshake.
// ----------------------------------------------------------------------------
module sbda_ctrl #(
  parameter int VALUE_BITS = sbda_pkg::VALUE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  sbda_pkg::status_t status,
  output sbda_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

  sbda_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // handshake and command decode
  always_comb begin
    in_ready     = (state == sbda_pkg::ST_IDLE);
    out_valid    = (state == sbda_pkg::ST_SIGN) || (state == sbda_pkg::ST_DIGIT);
    out_last     = (state == sbda_pkg::ST_DIGIT) && status.ptr_zero;
    cmd.load     = in_ready && in_valid;
    cmd.step     = (state == sbda_pkg::ST_CONV);
    cmd.sel_sign = (state == sbda_pkg::ST_SIGN);
    cmd.emit     = (state == sbda_pkg::ST_DIGIT) && out_ready && !status.ptr_zero;
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      sbda_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sbda_pkg::ST_CONV;
          cnt_next   = CNT_LAST;
        end
      end
      sbda_pkg::ST_CONV: begin
        if (cnt == '0) begin
          state_next = status.negative ? sbda_pkg::ST_SIGN : sbda_pkg::ST_DIGIT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      sbda_pkg::ST_SIGN: begin
        if (out_ready) begin
          state_next = sbda_pkg::ST_DIGIT;
        end
      end
      sbda_pkg::ST_DIGIT: begin
        if (out_ready && status.ptr_zero) begin
          state_next = sbda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbda_pkg::ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbda_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
